// ===== design/sli_pkg.sv =====
// Package: shared constants, payload structs and state codes for the list intersect unit
package sli_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    // command codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_PROBE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] item_value;
    } item_t;

    typedef struct packed {
        logic [31:0] match_value;
        logic        load_overflow;
    } result_t;

    // memory access request from the search controller to the store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // result handed from the controller to the output register
    typedef struct packed {
        logic    valid;
        result_t data;
    } emit_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAL_RD,
        ST_GAL_CMP,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_BIN_RD,
        ST_BIN_CMP,
        ST_FIN_RD,
        ST_FIN_CMP
    } state_t;

endpackage

// ===== design/sli_store.sv =====
// List store: one write port, one registered read port
module sli_store
    import sli_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [31:0] rd_data
);

    logic [31:0] mem [LIST_DEPTH];
    logic [31:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port: data held until the next read
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sli_ctrl.sv =====
// Search controller: list count, pointer, overflow flag and gallop/binary search sequencer
module sli_ctrl
    import sli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        acc,
    input  item_t       item,
    input  logic        slot_free,
    input  logic [31:0] rd_data,
    output logic        idle,
    output mem_req_t    mem_req,
    output emit_t       emit
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               ovf_reg, ovf_next;
    logic [31:0]        val_reg, val_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W:0]     hi_reg, hi_next;
    logic [CNT_W:0]     step_reg, step_next;
    logic [CNT_W-1:0]   first_reg, first_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;

    logic [CNT_W:0]     count_ext;
    logic [CNT_W-1:0]   half;
    logic [CNT_W-1:0]   mid;

    assign count_ext = {1'b0, count_reg};
    assign half      = len_reg >> 1;
    assign mid       = first_reg + half;
    assign idle      = (state_reg == ST_IDLE);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            ovf_reg   <= ovf_next;
        end
    end

    // search working registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        step_reg  <= step_next;
        first_reg <= first_next;
        len_reg   <= len_next;
        mid_reg   <= mid_next;
    end

    // next state, memory requests and result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        ovf_next   = ovf_reg;
        val_next   = val_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        step_next  = step_reg;
        first_next = first_reg;
        len_next   = len_reg;
        mid_next   = mid_reg;

        mem_req       = '0;
        mem_req.wdata = item.item_value;

        emit                    = '0;
        emit.data.match_value   = val_reg;
        emit.data.load_overflow = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (item.cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            ptr_next   = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (count_reg < CNT_W'(LIST_DEPTH))
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[ADDR_W-1:0];
                                count_next    = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_PROBE:
                        begin
                            if (ptr_reg < count_reg)
                            begin
                                val_next   = item.item_value;
                                lo_next    = ptr_reg;
                                hi_next    = {1'b0, ptr_reg};
                                step_next  = (CNT_W+1)'(1);
                                state_next = ST_GAL_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // gallop: read hi while it is inside the list, else clamp
            ST_GAL_RD:
            begin
                if (hi_reg < count_ext)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = hi_reg[ADDR_W-1:0];
                    state_next    = ST_GAL_CMP;
                end
                else
                begin
                    hi_next    = count_ext - 1'b1;
                    state_next = ST_CHK_RD;
                end
            end
            ST_GAL_CMP:
            begin
                if (rd_data < val_reg)
                begin
                    lo_next    = hi_reg[CNT_W-1:0] + 1'b1;
                    hi_next    = hi_reg + step_reg;
                    step_next  = step_reg << 1;
                    state_next = ST_GAL_RD;
                end
                else
                begin
                    state_next = ST_CHK_RD;
                end
            end
            // bracket check on the (clamped) upper bound
            ST_CHK_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = hi_reg[ADDR_W-1:0];
                state_next    = ST_CHK_CMP;
            end
            ST_CHK_CMP:
            begin
                if ((rd_data < val_reg) || ({1'b0, lo_reg} > hi_reg))
                begin
                    ptr_next   = count_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    first_next = lo_reg;
                    len_next   = hi_reg[CNT_W-1:0] + 1'b1 - lo_reg;
                    state_next = ST_BIN_RD;
                end
            end
            // binary search over [first, first + len)
            ST_BIN_RD:
            begin
                if (len_reg != '0)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = mid[ADDR_W-1:0];
                    mid_next      = mid;
                    state_next    = ST_BIN_CMP;
                end
                else
                begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_BIN_CMP:
            begin
                if (rd_data < val_reg)
                begin
                    first_next = mid_reg + 1'b1;
                    len_next   = len_reg - half - 1'b1;
                end
                else
                begin
                    len_next = half;
                end
                state_next = ST_BIN_RD;
            end
            // final equality test at the landing index
            ST_FIN_RD:
            begin
                if (first_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = first_reg[ADDR_W-1:0];
                    state_next    = ST_FIN_CMP;
                end
                else
                begin
                    ptr_next   = first_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_CMP:
            begin
                if (rd_data == val_reg)
                begin
                    // hold here until the output register can take the match
                    if (slot_free)
                    begin
                        emit.valid = 1'b1;
                        ptr_next   = first_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next   = first_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reads stay within the written part of the store
    a_read_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |-> ({1'b0, mem_req.raddr} < count_reg))
        else $error("read beyond list count");

    // a match is only handed over when the output register is free
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> slot_free)
        else $error("match emitted into a full output register");

    // pointer never runs past the list
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg)
        else $error("search pointer beyond list count");

    // list length is frozen while a probe is in progress
    a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("list count changed during a search");

endmodule

// ===== design/sorted_list_intersect_unit.sv =====
// Top level: item handshake, list store, search controller and result register
//
// Holds one ascending list of up to LIST_DEPTH 32-bit values and intersects it with a stream of
// ascending probe values. A clear or load transfer completes without leaving the idle state, as
// does a probe arriving with the pointer already at the end of the list. Any other probe keeps
// the block busy through a gallop search from the pointer, a bracket check, a binary search and
// a final compare before the next item is accepted. The number of gallop reads and the number
// of binary-search steps both grow as log2 of the distance the pointer advances; a probe that
// runs off the end stops after the bracket check. The search time is set by the single read
// port of the list store: every gallop step, the bracket check, every binary-search step and
// the final compare issues a registered read and then compares the read data. A match is
// placed in the result register; the next item is accepted while it waits. A further match
// that finds the register still full holds the block in its final compare until the register
// is taken. The store is not cleared after reset and needs no clearing pass; only loaded
// entries are ever read.
module sorted_list_intersect_unit
    import sli_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic        acc;
    logic        idle;
    logic        slot_free;
    logic [31:0] rd_data;
    mem_req_t    mem_req;
    emit_t       emit;

    logic        result_valid_reg;
    result_t     result_reg;

    assign item_ready = idle;
    assign acc        = item_valid && idle;
    assign slot_free  = !result_valid_reg || result_ready;

    sli_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    sli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .item      (item),
        .slot_free (slot_free),
        .rd_data   (rd_data),
        .idle      (idle),
        .mem_req   (mem_req),
        .emit      (emit)
    );

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg <= emit.data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
